@@ src/hrs_pkg.sv @@
// hrs_pkg: shared types, codes and defaults for the heat rod stencil core
// no dependencies; imported by hrs_ctrl, hrs_dp and the top level

package hrs_pkg;

  // default sizes
  localparam int MAX_SECTIONS_DEF = 32;
  localparam int TEMP_WIDTH_DEF   = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_AMBIENT  = 2'd0;
  localparam logic [1:0] CFG_SECTIONS = 2'd1;
  localparam logic [1:0] CFG_GAIN     = 2'd2;

  // configuration reset values
  localparam logic [31:0] AMBIENT_RST  = 32'd0;
  localparam logic [5:0]  SECTIONS_RST = 6'd32;
  localparam logic [15:0] GAIN_RST     = 16'd16384;

  // item commands
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_SET  = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } hrs_op_t;

  // input item
  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         index;
    logic signed [31:0] value;
  } hrs_in_t;

  // result item
  typedef struct packed {
    logic [4:0]         position;
    logic signed [31:0] temperature;
    logic               bad_index;
    logic               saturated;
    logic               last;
  } hrs_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic init;
    logic set_do;
    logic rd_issue;
    logic rd_do;
    logic sweep_run;
  } hrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic adv;
    logic slot_ghost;
    logic pipe_empty;
  } hrs_stat_t;

endpackage

@@ src/hrs_ram.sv @@
// hrs_ram: generic single write port, single read port ram with registered read
// no dependencies

module hrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/hrs_ctrl.sv @@
// hrs_ctrl: command sequencer of the heat rod stencil core
// depends on hrs_pkg (op codes, command and status structs)

module hrs_ctrl
  import hrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  output hrs_cmd_t   cmd,
  input  hrs_stat_t  stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SET,
    ST_RD_ISSUE,
    ST_RD_OUT,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (hrs_op_t'(in_op))
            OP_INIT: state_next = ST_INIT;
            OP_SET:  state_next = ST_SET;
            OP_TICK: state_next = ST_SWEEP;
            OP_READ: state_next = ST_RD_ISSUE;
          endcase
        end
      end
      ST_INIT:     state_next = ST_IDLE;
      ST_SET:      if (stat.adv) state_next = ST_IDLE;
      ST_RD_ISSUE: state_next = ST_RD_OUT;
      ST_RD_OUT:   if (stat.adv) state_next = ST_IDLE;
      ST_SWEEP:    if (stat.adv && stat.slot_ghost) state_next = ST_DRAIN;
      ST_DRAIN:    if (stat.pipe_empty) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command decode
  assign in_ready      = (state == ST_IDLE);
  assign cmd.latch     = in_valid && (state == ST_IDLE);
  assign cmd.init      = (state == ST_INIT);
  assign cmd.set_do    = (state == ST_SET);
  assign cmd.rd_issue  = (state == ST_RD_ISSUE);
  assign cmd.rd_do     = (state == ST_RD_OUT);
  assign cmd.sweep_run = (state == ST_SWEEP);

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> stat.pipe_empty)
    else $error("pipeline busy while idle");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_do |-> ($past(cmd.rd_issue) || $past(cmd.rd_do)))
    else $error("read result without ram read");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && stat.pipe_empty) |=> in_ready)
    else $error("sweep drain did not return to idle");

endmodule

@@ src/hrs_dp.sv @@
// hrs_dp: datapath of the heat rod stencil core: config, rod ram, stencil pipeline
// depends on hrs_pkg (structs, codes) and hrs_ram

module hrs_dp
  import hrs_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int TEMP_WIDTH   = TEMP_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  hrs_in_t     in_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hrs_out_t    out_data,
  input  hrs_cmd_t    cmd,
  output hrs_stat_t   stat
);

  localparam int TW  = TEMP_WIDTH;
  localparam int AW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW  = $clog2(MAX_SECTIONS + 1);
  localparam int LPW = TW + 2;
  localparam int HIW = LPW - 16;
  localparam int HW  = TW + 3;
  localparam int SW  = TW + 4;
  localparam int LW  = (SW > 33) ? SW : 33;

  // clamp to the temperature range, returns {clamped, value}
  function automatic logic [TW:0] sat_fn(input logic signed [LW-1:0] v);
    logic          ovf;
    logic [TW-1:0] r;
    ovf = !((&v[LW-1:TW-1]) || !(|v[LW-1:TW-1]));
    if (ovf) begin
      r = v[LW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      r = v[TW-1:0];
    end
    return {ovf, r};
  endfunction

  // configuration registers
  logic signed [31:0] cfg_ambient;
  logic [5:0]         cfg_sections;
  logic [15:0]        cfg_gain;

  // rod state outside the ram
  logic signed [TW-1:0]    fill;
  logic [MAX_SECTIONS-1:0] ent_valid;
  logic [MAX_SECTIONS-1:0] pin;

  // latched item
  logic [4:0]         lat_index;
  logic signed [31:0] lat_value;

  // sweep counter and pipeline
  logic [CW-1:0]         cnt;
  logic                  a_vld, a_ghost, a_ent, a_pin;
  logic [CW-1:0]         a_idx;
  logic                  w_vld, w_pin;
  logic [CW-1:0]         w_idx;
  logic signed [TW-1:0]  w_cur, w_left;
  logic                  b_vld, b_pin, b_last;
  logic [CW-1:0]         b_idx;
  logic signed [LPW-1:0] b_lap;
  logic signed [TW-1:0]  b_t;
  logic                  c_vld, c_pin, c_last;
  logic [CW-1:0]         c_idx;
  logic signed [HW-1:0]  c_hik;
  logic [31:0]           c_lok;
  logic signed [TW-1:0]  c_t;

  // combinational signals
  logic [CW-1:0]         n;
  logic [TW:0]           amb_sat, set_sat, res_sat;
  logic signed [TW-1:0]  amb, set_val, rd_val, a_val, tick_res;
  logic                  tick_flag;
  logic                  adv, slot_issue, slot_ghost, lat_bad;
  logic                  tick_wr, set_wr, re, we;
  logic [AW-1:0]         raddr, waddr, lat_addr, c_addr;
  logic [TW-1:0]         wdata, q;
  logic signed [LPW-1:0] lap_next;
  logic signed [HIW-1:0] b_hi;
  logic signed [16:0]    kk;
  logic [16:0]           rnd;
  logic signed [SW-1:0]  sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ambient  <= AMBIENT_RST;
      cfg_sections <= SECTIONS_RST;
      cfg_gain     <= GAIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AMBIENT:  cfg_ambient  <= cfg_wr_data;
        CFG_SECTIONS: cfg_sections <= cfg_wr_data[5:0];
        CFG_GAIN:     cfg_gain     <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // effective section count
  always_comb begin
    if (cfg_sections == '0) begin
      n = CW'(1);
    end else if (7'(cfg_sections) > 7'(MAX_SECTIONS)) begin
      n = CW'(MAX_SECTIONS);
    end else begin
      n = CW'(cfg_sections);
    end
  end

  // clamped ambient and source values
  assign amb_sat = sat_fn(LW'(cfg_ambient));
  assign amb     = amb_sat[TW-1:0];
  assign set_sat = sat_fn(LW'(lat_value));
  assign set_val = set_sat[TW-1:0];

  // handshake and sweep control
  assign adv        = !out_valid || out_ready;
  assign slot_issue = cmd.sweep_run && adv;
  assign slot_ghost = (cnt == n);
  assign lat_bad    = ({2'b00, lat_index} >= 7'(n));
  assign lat_addr   = AW'(lat_index);
  assign c_addr     = AW'(c_idx);

  assign stat.adv        = adv;
  assign stat.slot_ghost = slot_ghost;
  assign stat.pipe_empty = !(a_vld || b_vld || c_vld);

  // ram port selection
  assign tick_wr = adv && c_vld;
  assign set_wr  = cmd.set_do && adv && !lat_bad;
  assign we      = tick_wr || set_wr;
  assign waddr   = tick_wr ? c_addr : lat_addr;
  assign wdata   = tick_wr ? tick_res : set_val;
  assign re      = slot_issue || cmd.rd_issue;
  assign raddr   = cmd.rd_issue ? lat_addr : AW'(cnt);

  hrs_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_SECTIONS)
  ) u_rod (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (q)
  );

  // entry value, unwritten entries read as the fill value
  assign rd_val = a_ent ? q : fill;
  assign a_val  = a_ghost ? amb : rd_val;

  // stencil arithmetic
  assign lap_next = LPW'(a_val) - (LPW'(w_cur) <<< 1) + LPW'(w_left);
  assign b_hi     = b_lap[LPW-1:16];
  assign kk       = {1'b0, cfg_gain};
  assign rnd      = 17'((33'(c_lok) + 33'h0_8000) >> 16);
  assign sum      = SW'(c_t) + SW'(c_hik) + SW'(signed'({1'b0, rnd}));
  assign res_sat  = sat_fn(LW'(sum));
  assign tick_res = c_pin ? c_t : res_sat[TW-1:0];
  assign tick_flag = !c_pin && res_sat[TW];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ent_valid <= '0;
      pin       <= '0;
      cnt       <= '0;
      a_vld     <= 1'b0;
      w_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init) begin
        fill      <= amb;
        ent_valid <= '0;
        pin       <= '0;
      end else begin
        if (tick_wr) begin
          ent_valid[c_addr] <= 1'b1;
        end
        if (set_wr) begin
          ent_valid[lat_addr] <= 1'b1;
          pin[lat_addr]       <= 1'b1;
        end
      end
      if (!cmd.sweep_run) begin
        cnt <= '0;
      end else if (adv) begin
        cnt <= cnt + CW'(1);
      end
      if (adv) begin
        a_vld <= slot_issue;
        if (a_vld) begin
          w_vld <= !a_ghost;
        end
        b_vld     <= a_vld && w_vld;
        c_vld     <= b_vld;
        out_valid <= c_vld || cmd.set_do || cmd.rd_do;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_index <= in_data.index;
      lat_value <= in_data.value;
    end
    if (re) begin
      a_ent <= ent_valid[raddr];
      a_pin <= pin[raddr];
    end
    if (slot_issue) begin
      a_idx   <= cnt;
      a_ghost <= slot_ghost;
    end
    // neighbor window
    if (adv && a_vld) begin
      w_cur  <= a_val;
      w_left <= (a_idx == '0) ? amb : w_cur;
      w_idx  <= a_idx;
      w_pin  <= a_pin;
    end
    // laplacian, then gain products
    if (adv) begin
      b_lap  <= lap_next;
      b_t    <= w_cur;
      b_idx  <= w_idx;
      b_pin  <= w_pin;
      b_last <= a_ghost;
      c_hik  <= HW'(b_hi) * HW'(kk);
      c_lok  <= 32'(b_lap[15:0]) * 32'(cfg_gain);
      c_t    <= b_t;
      c_idx  <= b_idx;
      c_pin  <= b_pin;
      c_last <= b_last;
    end
    // output register
    if (adv) begin
      if (c_vld) begin
        out_data.position    <= 5'(c_idx);
        out_data.temperature <= 32'(tick_res);
        out_data.bad_index   <= 1'b0;
        out_data.saturated   <= tick_flag;
        out_data.last        <= c_last;
      end else if (cmd.set_do || cmd.rd_do) begin
        out_data.position    <= lat_index;
        out_data.bad_index   <= lat_bad;
        out_data.saturated   <= 1'b0;
        out_data.last        <= 1'b1;
        if (lat_bad) begin
          out_data.temperature <= '0;
        end else if (cmd.set_do) begin
          out_data.temperature <= 32'(set_val);
        end else begin
          out_data.temperature <= 32'(rd_val);
        end
      end
    end
  end

  // checks
  a_set_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.set_do |-> !(a_vld || b_vld || c_vld))
    else $error("set source overlaps a sweep");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (c_vld && c_last) |-> ((c_idx + CW'(1)) == n))
    else $error("last flag not on final section");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(tick_wr && set_wr))
    else $error("two ram writers in one cycle");

endmodule

@@ src/heat_rod_stencil_step_core.sv @@
// heat_rod_stencil_step_core: top level of the 1-d explicit heat diffusion rod
// depends on hrs_pkg, hrs_ctrl, hrs_dp (which holds hrs_ram)

// The rod's temperatures live in a single-port-read ram of MAX_SECTIONS
// entries of TEMP_WIDTH bits; a valid bit per entry lets init skip a clearing
// pass, and unwritten entries read as the ambient value captured at the last
// init. One item is handled at a time. Init gives no result; a set source
// writes an in-range entry and registers its result, and a read first reads
// the ram and then registers the result. A tick streams the sections through
// the ram read port one per cycle into a four-stage stencil pipeline (window,
// laplacian, gain multiply, round and clamp with write-back), and both pause
// while the output is stalled. A finished result may wait in the output
// register while the next item is accepted.

module heat_rod_stencil_step_core
  import hrs_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int TEMP_WIDTH   = TEMP_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hrs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hrs_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wr_data
);

  hrs_cmd_t  cmd;
  hrs_stat_t stat;

  // sequencer
  hrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.cmd),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath
  hrs_dp #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .TEMP_WIDTH   (TEMP_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
